// ===== design/bdsl_pkg.sv =====
// Shared types, constants and codes for the bounded deque with sorted insert.
package bdsl_pkg;

  // Number of cells in the chain, and the widths that follow from it.
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed widths of the result fields.
  localparam int POS_OUT_W = 4;
  localparam int CNT_OUT_W = 5;

  // Request codes carried in req_type.
  typedef enum logic [2:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_BACK   = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_INSERT     = 3'd4,
    REQ_FIND       = 3'd5,
    REQ_DELETE     = 3'd6
  } req_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // What a cell does with its word at the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_LEFT  = 2'd2,
    CELL_RIGHT = 2'd3
  } cell_action_t;

  typedef struct packed {
    cell_action_t action;
  } cell_ctl_t;

  // Comparison flags that each cell reports against the request value.
  typedef struct packed {
    logic eq;
    logic lt;
  } cell_flags_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_status;
    logic [3:0] found_position;
    logic [4:0] element_count;
  } out_item_t;

endpackage

// ===== design/bdsl_cell.sv =====
// One cell of the chain: holds a single word and compares it with the request value.
module bdsl_cell (
  input  logic                    clk,
  input  bdsl_pkg::cell_ctl_t     ctl,
  input  logic signed [31:0]      value,
  input  logic signed [31:0]      left_word,
  input  logic signed [31:0]      right_word,
  output logic signed [31:0]      word,
  output bdsl_pkg::cell_flags_t   flags
);

  logic signed [31:0] word_next;

  // Select the new word: keep, take the request value, or take a neighbour's word.
  always_comb begin
    case (ctl.action)
      bdsl_pkg::CELL_HOLD:  word_next = word;
      bdsl_pkg::CELL_LOAD:  word_next = value;
      bdsl_pkg::CELL_LEFT:  word_next = left_word;
      bdsl_pkg::CELL_RIGHT: word_next = right_word;
      default:              word_next = word;
    endcase
  end

  // The stored word needs no reset; entries are only read below the fill count.
  always_ff @(posedge clk) begin
    word <= word_next;
  end

  // Signed comparison against the request value.
  always_comb begin
    flags.eq = (word == value);
    flags.lt = (word < value);
  end

endmodule

// ===== design/bounded_deque_sorted_list.sv =====
// Top level: control, fill count, chain of cells and result register of the deque.
// A request accepted at a clock edge has its result registered in the output register at that edge.
// Throughput: one item per cycle while results are taken; every request is settled in the cycle it is accepted,
// as each cell compares its word with the value and shifts to or from its neighbours at once.
// The input is ready whenever the result register is empty or is being taken.
// Reset clears the fill count and the result valid; stored words are not cleared.
module bounded_deque_sorted_list (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bdsl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bdsl_pkg::out_item_t out_data
);

  localparam int N = bdsl_pkg::CAPACITY;

  logic [bdsl_pkg::CNT_W-1:0] count;
  logic [bdsl_pkg::CNT_W-1:0] count_next;
  logic                       fire;

  logic signed [31:0]    words [N];
  bdsl_pkg::cell_flags_t flags [N];
  bdsl_pkg::cell_ctl_t   ctls  [N];

  logic [N-1:0] live;
  logic [N-1:0] hit;
  logic [N-1:0] hit_first;
  logic [N-1:0] hit_after;
  logic [N-1:0] ins_first;
  logic [N-1:0] ins_after;
  logic         any_hit;
  logic         is_full;
  logic         is_empty;
  logic [bdsl_pkg::IDX_W-1:0] hit_pos;

  bdsl_pkg::status_t   status;
  logic                found_pos_en;
  bdsl_pkg::out_item_t out_data_next;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;
  assign is_full  = (count == bdsl_pkg::CNT_W'(N));
  assign is_empty = (count == '0);

  // Chain of cells; each cell sees its two neighbours, but the first takes the request value and the last its own word.
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [31:0] left_w;
    logic signed [31:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = in_data.value;
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right_w = words[i];
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end
    bdsl_cell u_cell (
      .clk        (clk),
      .ctl        (ctls[i]),
      .value      (in_data.value),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (words[i]),
      .flags      (flags[i])
    );
  end

  // Per-cell match and ordering masks, with their first positions and prefixes.
  always_comb begin
    logic acc_hit;
    logic acc_ins;
    acc_hit = 1'b0;
    acc_ins = 1'b0;
    for (int i = 0; i < N; i++) begin
      live[i]      = (bdsl_pkg::CNT_W'(i) < count);
      hit[i]       = live[i] && flags[i].eq;
      hit_first[i] = hit[i] && !acc_hit;
      acc_hit      = acc_hit || hit[i];
      hit_after[i] = acc_hit;
      ins_first[i] = !(live[i] && flags[i].lt) && !acc_ins;
      acc_ins      = acc_ins || !(live[i] && flags[i].lt);
      ins_after[i] = acc_ins;
    end
    any_hit = acc_hit;
  end

  // Position of the first match.
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < N; i++) begin
      if (hit_first[i]) begin
        hit_pos = hit_pos | bdsl_pkg::IDX_W'(i);
      end
    end
  end

  // Request decode: status, new count and the action of every cell.
  always_comb begin
    status       = bdsl_pkg::ST_OK;
    found_pos_en = 1'b0;
    count_next   = count;
    for (int i = 0; i < N; i++) begin
      ctls[i].action = bdsl_pkg::CELL_HOLD;
    end
    case (in_data.req_type)
      bdsl_pkg::REQ_PUSH_BACK: begin
        if (is_full) begin
          status = bdsl_pkg::ST_FULL;
        end else begin
          count_next = count + 1'b1;
          for (int i = 0; i < N; i++) begin
            if (bdsl_pkg::CNT_W'(i) == count) ctls[i].action = bdsl_pkg::CELL_LOAD;
          end
        end
      end
      bdsl_pkg::REQ_PUSH_FRONT: begin
        if (is_full) begin
          status = bdsl_pkg::ST_FULL;
        end else begin
          count_next = count + 1'b1;
          for (int i = 0; i < N; i++) begin
            ctls[i].action = (i == 0) ? bdsl_pkg::CELL_LOAD : bdsl_pkg::CELL_LEFT;
          end
        end
      end
      bdsl_pkg::REQ_POP_BACK: begin
        if (is_empty) begin
          status = bdsl_pkg::ST_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      bdsl_pkg::REQ_POP_FRONT: begin
        if (is_empty) begin
          status = bdsl_pkg::ST_EMPTY;
        end else begin
          count_next = count - 1'b1;
          for (int i = 0; i < N; i++) begin
            ctls[i].action = bdsl_pkg::CELL_RIGHT;
          end
        end
      end
      bdsl_pkg::REQ_INSERT: begin
        if (is_empty) begin
          status = bdsl_pkg::ST_EMPTY;
        end else if (is_full) begin
          status = bdsl_pkg::ST_FULL;
        end else begin
          count_next = count + 1'b1;
          for (int i = 0; i < N; i++) begin
            if (ins_first[i]) begin
              ctls[i].action = bdsl_pkg::CELL_LOAD;
            end else if (ins_after[i]) begin
              ctls[i].action = bdsl_pkg::CELL_LEFT;
            end
          end
        end
      end
      bdsl_pkg::REQ_FIND: begin
        if (any_hit) begin
          found_pos_en = 1'b1;
        end else begin
          status = bdsl_pkg::ST_NOT_FOUND;
        end
      end
      bdsl_pkg::REQ_DELETE: begin
        if (is_empty) begin
          status = bdsl_pkg::ST_EMPTY;
        end else if (!any_hit) begin
          status = bdsl_pkg::ST_NOT_FOUND;
        end else begin
          count_next = count - 1'b1;
          for (int i = 0; i < N; i++) begin
            if (hit_after[i]) ctls[i].action = bdsl_pkg::CELL_RIGHT;
          end
        end
      end
      default: begin
        status = bdsl_pkg::ST_OK;
      end
    endcase
    // Nothing moves unless the item is actually taken.
    if (!fire) begin
      for (int i = 0; i < N; i++) begin
        ctls[i].action = bdsl_pkg::CELL_HOLD;
      end
    end
  end

  // Assemble the result item.
  always_comb begin
    out_data_next.result_status  = status;
    out_data_next.found_position =
      found_pos_en ? bdsl_pkg::POS_OUT_W'(hit_pos) : '0;
    out_data_next.element_count  = bdsl_pkg::CNT_OUT_W'(count_next);
  end

  // Fill count and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        count <= count_next;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= out_data_next;
    end
  end

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= bdsl_pkg::CNT_W'(N))
    else $error("fill count above capacity");

  // The count only moves when an item is taken.
  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(count))
    else $error("fill count changed without an item");

  // A taken item leaves its result waiting, carrying the new count.
  a_result_count: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid && (out_data.element_count == bdsl_pkg::CNT_OUT_W'(count)))
    else $error("result count does not match fill count");

  // A find that succeeds names a live entry.
  a_found_live: assert property (@(posedge clk) disable iff (rst)
    fire && found_pos_en |-> live[hit_pos])
    else $error("found position outside the held elements");

endmodule

// ===== bench/bdsl_checker.sv =====
// Result checker for the bounded deque: tracks the list contents and compares every result.
module bdsl_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  bdsl_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  bdsl_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending_count
);

  // Shadow copy of the list, front at index 0, and the results still owed by the block.
  logic signed [31:0]  list_words[$];
  bdsl_pkg::out_item_t owed_results[$];

  // Apply one request to the shadow list and return the result it should produce.
  function automatic bdsl_pkg::out_item_t apply_request(bdsl_pkg::in_item_t req);
    bdsl_pkg::out_item_t res;
    int                  idx;
    logic signed [31:0]  v;
    res = '0;
    res.result_status = bdsl_pkg::ST_OK;
    v = $signed(req.value);
    case (req.req_type)
      bdsl_pkg::REQ_PUSH_BACK: begin
        if (list_words.size() >= bdsl_pkg::CAPACITY) res.result_status = bdsl_pkg::ST_FULL;
        else list_words.insert(list_words.size(), v);
      end
      bdsl_pkg::REQ_PUSH_FRONT: begin
        if (list_words.size() >= bdsl_pkg::CAPACITY) res.result_status = bdsl_pkg::ST_FULL;
        else list_words.insert(0, v);
      end
      bdsl_pkg::REQ_POP_BACK: begin
        if (list_words.size() == 0) res.result_status = bdsl_pkg::ST_EMPTY;
        else list_words.delete(list_words.size() - 1);
      end
      bdsl_pkg::REQ_POP_FRONT: begin
        if (list_words.size() == 0) res.result_status = bdsl_pkg::ST_EMPTY;
        else list_words.delete(0);
      end
      bdsl_pkg::REQ_INSERT: begin
        if (list_words.size() == 0) res.result_status = bdsl_pkg::ST_EMPTY;
        else if (list_words.size() >= bdsl_pkg::CAPACITY) res.result_status = bdsl_pkg::ST_FULL;
        else begin
          // The new word goes before the first one that is not less than it.
          idx = 0;
          while (idx < list_words.size() && list_words[idx] < v) idx++;
          list_words.insert(idx, v);
        end
      end
      bdsl_pkg::REQ_FIND: begin
        idx = 0;
        while (idx < list_words.size() && list_words[idx] != v) idx++;
        if (idx >= list_words.size()) res.result_status = bdsl_pkg::ST_NOT_FOUND;
        else res.found_position = 4'(idx);
      end
      bdsl_pkg::REQ_DELETE: begin
        if (list_words.size() == 0) res.result_status = bdsl_pkg::ST_EMPTY;
        else begin
          idx = 0;
          while (idx < list_words.size() && list_words[idx] != v) idx++;
          if (idx >= list_words.size()) res.result_status = bdsl_pkg::ST_NOT_FOUND;
          else list_words.delete(idx);
        end
      end
      default: begin
        // The unused code leaves everything as it is.
      end
    endcase
    res.element_count = 5'(list_words.size());
    return res;
  endfunction

  // Compare the result taken at this edge first, then predict the item accepted at it.
  always @(posedge clk) begin
    int                  errs;
    bdsl_pkg::out_item_t want;
    errs = 0;
    if (rst) begin
      list_words.delete();
      owed_results.delete();
      pending_count <= 0;
      fail_count    <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          $error("result item with no request waiting: status %0d position %0d count %0d",
                 out_data.result_status, out_data.found_position, out_data.element_count);
          errs++;
        end else begin
          want = owed_results[0];
          owed_results.delete(0);
          if (out_data.result_status !== want.result_status) begin
            $error("result_status: expected %0d, actual %0d",
                   want.result_status, out_data.result_status);
            errs++;
          end
          if (out_data.found_position !== want.found_position) begin
            $error("found_position: expected %0d, actual %0d",
                   want.found_position, out_data.found_position);
            errs++;
          end
          if (out_data.element_count !== want.element_count) begin
            $error("element_count: expected %0d, actual %0d",
                   want.element_count, out_data.element_count);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        owed_results.insert(owed_results.size(), apply_request(in_data));
      end
      pending_count <= owed_results.size();
      fail_count    <= fail_count + errs;
    end
  end

endmodule

// ===== bench/tb_bounded_deque_sorted_list.sv =====
// Testbench top for the bounded deque: clock, reset, request stimulus, back-pressure and verdict.
module tb_bounded_deque_sorted_list;

  // Request code that the block does not use; it must leave the list alone.
  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam int IDLE_LIMIT = 4000;
  localparam int PHASE_ITEMS = 150;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  bdsl_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  bdsl_pkg::out_item_t out_data;

  int fail_count;
  int pending_count;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  // Clock with a period of two units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bounded_deque_sorted_list uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  bdsl_checker checker_inst (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog: too many cycles without any item moving ends the run.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
        $display("FAIL bounded_deque_sorted_list");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one request, with random idle cycles before it, and hold it until accepted.
  task automatic send_item(input logic [2:0] code, input logic signed [31:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data.req_type <= code;
    in_data.value    <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait until every owed result has been taken.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // Mostly a few small values so that finds, deletes and ties hit, plus extremes and noise.
  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return $signed($urandom_range(0, 7)) - 4;
    if (r < 55) begin
      case ($urandom_range(0, 2))
        0:       return WORD_MIN;
        1:       return WORD_MAX;
        default: return -1;
      endcase
    end
    return $signed($urandom());
  endfunction

  // Request mix: one leaning to filling, one to draining, one balanced.
  function automatic logic [2:0] pick_code(input int bias);
    int r;
    int cut[7];
    r = $urandom_range(0, 99);
    case (bias)
      0:       cut = '{30, 50, 75, 85, 92, 96, 99};
      1:       cut = '{10, 18, 28, 43, 65, 82, 99};
      default: cut = '{15, 28, 45, 60, 75, 86, 98};
    endcase
    if (r < cut[0]) return bdsl_pkg::REQ_PUSH_BACK;
    if (r < cut[1]) return bdsl_pkg::REQ_PUSH_FRONT;
    if (r < cut[2]) return bdsl_pkg::REQ_INSERT;
    if (r < cut[3]) return bdsl_pkg::REQ_FIND;
    if (r < cut[4]) return bdsl_pkg::REQ_DELETE;
    if (r < cut[5]) return bdsl_pkg::REQ_POP_BACK;
    if (r < cut[6]) return bdsl_pkg::REQ_POP_FRONT;
    return REQ_UNUSED;
  endfunction

  initial begin
    int bias;
    rst <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Requests on an empty list, and the unused code.
    send_item(bdsl_pkg::REQ_POP_BACK, 0);
    send_item(bdsl_pkg::REQ_POP_FRONT, 0);
    send_item(bdsl_pkg::REQ_DELETE, 5);
    send_item(bdsl_pkg::REQ_FIND, 5);
    send_item(bdsl_pkg::REQ_INSERT, 5);
    send_item(REQ_UNUSED, 32'sh1234_5678);

    // Ordered inserts at the back, in the middle and at the front, with extreme words.
    send_item(bdsl_pkg::REQ_PUSH_BACK, WORD_MIN);
    send_item(bdsl_pkg::REQ_PUSH_BACK, 0);
    send_item(bdsl_pkg::REQ_INSERT, WORD_MAX);
    send_item(bdsl_pkg::REQ_INSERT, -1);
    send_item(bdsl_pkg::REQ_INSERT, WORD_MIN);
    send_item(bdsl_pkg::REQ_FIND, WORD_MAX);
    send_item(bdsl_pkg::REQ_FIND, 7);
    send_item(bdsl_pkg::REQ_DELETE, 7);
    // Delete at the tail, then in the middle, then pops at both ends.
    send_item(bdsl_pkg::REQ_DELETE, WORD_MAX);
    send_item(bdsl_pkg::REQ_DELETE, -1);
    send_item(bdsl_pkg::REQ_POP_FRONT, 0);
    send_item(bdsl_pkg::REQ_POP_BACK, 0);
    send_item(bdsl_pkg::REQ_PUSH_FRONT, WORD_MAX);

    // Fill the list to capacity, then push and insert into a full list.
    for (int k = 0; k < bdsl_pkg::CAPACITY - 2; k++) begin
      send_item((k % 2 != 0) ? bdsl_pkg::REQ_PUSH_FRONT : bdsl_pkg::REQ_PUSH_BACK, k * 3 - 20);
    end
    send_item(bdsl_pkg::REQ_PUSH_BACK, 1);
    send_item(bdsl_pkg::REQ_PUSH_FRONT, 1);
    send_item(bdsl_pkg::REQ_INSERT, 1);
    // The last word pushed at the back sits at the highest position.
    send_item(bdsl_pkg::REQ_FIND, 16);

    // Random requests in phases of sender and receiver idling.
    for (int ph = 0; ph < 8; ph++) begin
      wait_for_drain();
      case (ph % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) bias = $urandom_range(0, 2);
        send_item(pick_code(bias), pick_value());
      end
    end

    // Let every result come out, then watch for anything stray before the verdict.
    recv_stall_pct = 0;
    wait_for_drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS bounded_deque_sorted_list");
    end else begin
      $display("FAIL bounded_deque_sorted_list");
    end
    $finish;
  end

endmodule
